### hdl/e2t_pkg.sv
package e2t_pkg;

  // Charset register codes
  localparam logic [1:0] CS_EUC_JP = 2'd0;
  localparam logic [1:0] CS_EUC_CN = 2'd1;
  localparam logic [1:0] CS_EUC_KR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SECOND,
    PH_X0212,
    PH_TPLANE,
    PH_TROW,
    PH_TCELL
  } phase_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] code;
    logic [1:0]  status;
  } result_t;

  // JIS X 0212 row remap; zero means keep the row byte as it is
  function automatic logic [7:0] x0212_row(input logic [6:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (idx >= 7'd16 && idx <= 7'd32) begin
      r = 8'hDE + {1'b0, idx};
    end else if (idx >= 7'd110 && idx <= 7'd126) begin
      r = 8'd34 + {1'b0, idx};
    end else begin
      case (idx)
        7'd7:    r = 8'hA1;
        7'd8:    r = 8'hA3;
        7'd9:    r = 8'hA4;
        7'd10:   r = 8'hA5;
        7'd11:   r = 8'hA8;
        7'd12:   r = 8'hAC;
        7'd13:   r = 8'hAD;
        7'd14:   r = 8'hAE;
        7'd15:   r = 8'hAF;
        7'd33:   r = 8'h87;
        7'd35:   r = 8'h88;
        7'd36:   r = 8'h89;
        7'd37:   r = 8'h8A;
        7'd40:   r = 8'h8B;
        7'd44:   r = 8'h8C;
        7'd45:   r = 8'h8D;
        7'd46:   r = 8'h8E;
        7'd47:   r = 8'h8F;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  // A code byte must lie in 0x21..0xFD and not be DEL
  function automatic logic byte_bad(input logic [7:0] b);
    return (b == 8'h7F) || (b < 8'h21) || (b > 8'hFD);
  endfunction

endpackage

### hdl/e2t_remap.sv
// 94-by-126 row remap for EUC-CN and EUC-KR, truncating division by 126.
module e2t_remap (
  input  logic [7:0]  lead,
  input  logic [7:0]  trail,
  input  logic        korean,
  output logic [31:0] code
);

  localparam logic [14:0] RECIP = 15'd16645;  // ceil(2^21 / 126)

  logic signed [8:0]  cr;
  logic signed [8:0]  dr;
  logic signed [15:0] t;
  logic               neg;
  logic [13:0]        mag;
  logic [28:0]        prod;
  logic [7:0]         q;
  logic [13:0]        rem_wide;
  logic [6:0]         rem;
  logic [7:0]         base;
  logic [7:0]         hi;
  logic [7:0]         lo;

  always_comb begin
    cr       = $signed({1'b0, lead}) - 9'sd161;
    dr       = $signed({1'b0, trail}) - 9'sd161;
    t        = 16'(cr) * 16'sd94 + 16'(dr);
    neg      = t[15];
    mag      = neg ? 14'(-t) : 14'(t);
    prod     = 29'(mag) * 29'(RECIP);
    q        = prod[28:21];
    rem_wide = mag - 14'(q) * 14'd126;
    rem      = rem_wide[6:0];
    base     = korean ? 8'hB7 : 8'h21;
    hi       = neg ? (base - q) : (base + q);
    lo       = neg ? (8'h80 - {1'b0, rem}) : (8'h80 + {1'b0, rem});
    code     = {8'h00, 8'h21, hi, lo};
  end

endmodule

### hdl/e2t_step.sv
// Per-byte decode: sequence state and the result of the current byte.
module e2t_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  logic [7:0]        b,
  input  logic [1:0]        charset,
  output e2t_pkg::result_t  res
);

  localparam logic [31:0] ASCII_PLANE = 32'h0070_2200;
  localparam logic [31:0] KANA_PLANE  = 32'h0070_2300;
  localparam logic [31:0] X0212_MASK  = 32'h0021_0080;
  localparam logic [31:0] X0208_MASK  = 32'h0021_8080;

  e2t_pkg::phase_t phase, phase_next;
  logic [7:0]  lead_byte, lead_byte_next;
  logic [7:0]  second_byte, second_byte_next;
  logic [15:0] plane_acc, plane_acc_next;

  logic [31:0] remap_code;
  logic [31:0] v;
  logic        fin;
  logic        trunc;
  logic        emit;
  logic [7:0]  row;
  logic [31:0] p;
  logic [31:0] sw;
  logic [31:0] tron;

  e2t_remap u_remap (
    .lead   (lead_byte),
    .trail  (b),
    .korean (charset == e2t_pkg::CS_EUC_KR),
    .code   (remap_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= e2t_pkg::PH_IDLE;
    end else if (step_en) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      lead_byte   <= lead_byte_next;
      second_byte <= second_byte_next;
      plane_acc   <= plane_acc_next;
    end
  end

  // EUC-TRON final byte: row/cell folding onto the plane prefix
  always_comb begin
    p  = {plane_acc, 16'h0000} + {16'h0000, second_byte, 8'h00} + {24'h000000, b};
    sw = {p[31:16], 16'h0000} + {16'h0000, b, 8'h00} + {24'h000000, second_byte};
    case (lead_byte)
      8'h88:   tron = p ^ 32'h0000_8080;
      8'h89:   tron = p ^ 32'h0000_0080;
      8'h8A:   tron = p ^ 32'h0000_8000;
      8'h8B:   tron = p;
      8'h8C:   tron = (second_byte < 8'hC0) ? p - 32'h0000_2080 : sw - 32'h0000_8040;
      default: begin
        if (second_byte < 8'hC0) begin
          tron = p - 32'h0000_2000;
        end else if (second_byte < 8'hE0) begin
          tron = sw - 32'h0000_0040;
        end else begin
          tron = p - 32'h0000_6060;
        end
      end
    endcase
  end

  always_comb begin
    row = e2t_pkg::x0212_row(second_byte[6:0]);
    if (row == 8'h00) begin
      row = second_byte;
    end
  end

  always_comb begin
    phase_next       = phase;
    lead_byte_next   = lead_byte;
    second_byte_next = second_byte;
    plane_acc_next   = plane_acc;
    v                = 32'h0;
    fin              = 1'b0;
    trunc            = 1'b0;
    emit             = 1'b0;
    case (phase)
      e2t_pkg::PH_SECOND: begin
        if (b < 8'h80) begin
          trunc      = 1'b1;
          phase_next = e2t_pkg::PH_IDLE;
        end else if (charset == e2t_pkg::CS_EUC_CN || charset == e2t_pkg::CS_EUC_KR) begin
          fin        = 1'b1;
          v          = remap_code;
          phase_next = e2t_pkg::PH_IDLE;
        end else if (charset != e2t_pkg::CS_EUC_JP) begin
          fin        = 1'b1;
          phase_next = e2t_pkg::PH_IDLE;
        end else if (lead_byte == 8'h8F) begin
          second_byte_next = b;
          phase_next       = e2t_pkg::PH_X0212;
        end else if (lead_byte == 8'h8E) begin
          fin        = 1'b1;
          v          = {24'h000000, b} + KANA_PLANE;
          phase_next = e2t_pkg::PH_IDLE;
        end else if (lead_byte >= 8'h88 && lead_byte <= 8'h8D) begin
          if (b == 8'h90 || b == 8'h91) begin
            plane_acc_next = b[0] ? 16'h0000 : 16'hFFC0;
            phase_next     = e2t_pkg::PH_TPLANE;
          end else if (b == 8'h80) begin
            plane_acc_next = 16'h0080;
            phase_next     = e2t_pkg::PH_TPLANE;
          end else begin
            plane_acc_next = 16'hFF80 + {8'h00, b};
            phase_next     = e2t_pkg::PH_TROW;
          end
        end else begin
          fin        = 1'b1;
          v          = {16'h0000, lead_byte, 8'h00} ^ {24'h000000, b} ^ X0208_MASK;
          phase_next = e2t_pkg::PH_IDLE;
        end
      end
      e2t_pkg::PH_X0212: begin
        phase_next = e2t_pkg::PH_IDLE;
        if (b < 8'h80) begin
          trunc = 1'b1;
        end else begin
          fin = 1'b1;
          v   = {16'h0000, row, 8'h00} ^ {24'h000000, b} ^ X0212_MASK;
        end
      end
      e2t_pkg::PH_TPLANE: begin
        if (b == 8'h80) begin
          plane_acc_next = plane_acc + 16'h0100;
        end else begin
          plane_acc_next = plane_acc + {8'h00, b};
          phase_next     = e2t_pkg::PH_TROW;
        end
      end
      e2t_pkg::PH_TROW: begin
        second_byte_next = b;
        phase_next       = e2t_pkg::PH_TCELL;
      end
      e2t_pkg::PH_TCELL: begin
        fin        = 1'b1;
        v          = tron;
        phase_next = e2t_pkg::PH_IDLE;
      end
      default: begin
        phase_next = e2t_pkg::PH_IDLE;
        if (b == 8'h20) begin
          emit = 1'b1;
          v    = 32'h0000_0020;
        end else if (b < 8'h7F) begin
          emit = 1'b1;
          v    = {24'h000000, b} + ASCII_PLANE;
        end else begin
          lead_byte_next = b;
          phase_next     = e2t_pkg::PH_SECOND;
        end
      end
    endcase

    res.emit = emit || fin || trunc;
    res.code = v;
    if (trunc) begin
      res.status = e2t_pkg::ST_TRUNC;
    end else if (fin && (e2t_pkg::byte_bad(v[7:0]) || e2t_pkg::byte_bad(v[15:8])
                         || e2t_pkg::byte_bad(v[23:16]))) begin
      res.status = e2t_pkg::ST_BAD;
    end else begin
      res.status = e2t_pkg::ST_OK;
    end
  end

endmodule

### hdl/euc_to_tron_code_decoder_unit.sv
// EUC to TRON character code decoder.
//
// Input channel (in_valid/in_ready/in_byte) takes one byte of EUC-JP,
// EUC-TRON, EUC-CN or EUC-KR text per item. Output channel
// (out_valid/out_ready/tron_code/status) gives one 32-bit TRON code each
// time a character is finished; lead and middle bytes give no item.
// status: 0 ok, 1 truncated sequence (code zero), 2 invalid code (the
// rejected code is shown). After an error the decoder is back at idle.
// Config channel (cfg_valid/cfg_ready/charset_mode) selects the charset;
// it is always ready. The user must write it only while no sequence is open;
// the block itself does not enforce this. Throughput: one byte per cycle,
// sustained while out_ready stays high. The byte is held in an input register,
// decoded combinationally and its result lands in the output register.
// When the receiver stalls the output register holds its item and the
// input register fills; in_ready drops once both are occupied.
// Reset clears the sequence state to idle, empties both registers and
// sets the charset to EUC-JP.
module euc_to_tron_code_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] tron_code,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  charset_mode
);

  logic              in_full;
  logic [7:0]        in_data;
  logic [1:0]        charset;
  logic              step_en;
  e2t_pkg::result_t  res;

  // advance the held byte whenever the output register can take a result
  assign step_en   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || step_en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      charset <= e2t_pkg::CS_EUC_JP;
    end else if (cfg_valid) begin
      charset <= charset_mode;
    end
  end

  // input register: hold a byte until the decode step takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step_en) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data <= in_byte;
    end
  end

  e2t_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .b       (in_data),
    .charset (charset),
    .res     (res)
  );

  // output register: load a finished item, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.emit) begin
      tron_code <= res.code;
      status    <= res.status;
    end
  end

endmodule
